// File: sv/lpbw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpbw_pkg
// Shared types and constants of the login profile block: field widths,
// action codes, hash index constants and controller command groups.
// ----------------------------------------------------------------------------
package lpbw_pkg;

	localparam int FILTER_BITS_DEF = 2048;
	localparam int ROW_BITS        = 32;
	localparam int ROW_OFF_W       = 5;
	localparam int SECOND_SHIFT    = 11;
	localparam logic [63:0] THIRD_MULT = 64'd2654435761;

	localparam int HASH_W    = 64;
	localparam int HOUR_W    = 5;
	localparam int FRAC_BITS = 16;
	localparam int MEAN_W    = HOUR_W + FRAC_BITS;
	localparam int DIFF_W    = MEAN_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int CNT_W     = 32;
	localparam int SPREAD_W  = 63;
	localparam int DIV_STEPS = MEAN_W;

	localparam logic [1:0] ACT_LOGIN = 2'd0;
	localparam logic [1:0] ACT_ADD   = 2'd1;
	localparam logic [1:0] ACT_CHECK = 2'd2;

	localparam logic [1:0] K_LAST = 2'd2;

	typedef enum logic [1:0] {
		HSEL_DEV,
		HSEL_GEO,
		HSEL_QRY
	} hsel_t;

	typedef struct packed {
		logic  capture;
		logic  count;
		logic  div_step;
		logic  mean;
		logic  mult;
		logic  accum;
		logic  idx_load;
		logic  load_out;
		hsel_t hsel;
		logic [1:0] k;
	} dp_cmd_t;

	typedef struct packed {
		logic start;
		logic check;
		logic rd;
		logic set;
		logic test;
	} filt_cmd_t;

endpackage

// File: sv/lpbw_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpbw_filter
// Bloom filter storage in 32-bit rows with read-modify-write bit set, bit
// test with membership accumulation, and a row-by-row clearing sweep.
// ----------------------------------------------------------------------------
module lpbw_filter #(
	parameter int FILTER_BITS = lpbw_pkg::FILTER_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lpbw_pkg::filt_cmd_t            cmd,
	input  logic [$clog2(FILTER_BITS)-1:0] idx,
	output logic                           clr_busy,
	output logic                           member
);

	localparam int IW   = $clog2(FILTER_BITS);
	localparam int ROWS = FILTER_BITS / lpbw_pkg::ROW_BITS;
	localparam int RW   = $clog2(ROWS);

	logic [lpbw_pkg::ROW_BITS-1:0] mem [ROWS];
	logic [lpbw_pkg::ROW_BITS-1:0] rd_q;
	logic [lpbw_pkg::ROW_BITS-1:0] mask;
	logic [RW-1:0]                 row;
	logic [lpbw_pkg::ROW_OFF_W-1:0] off;
	logic [RW-1:0]                 clr_q;
	logic                          clr_busy_q;
	logic                          member_q;

	assign row  = idx[IW-1:lpbw_pkg::ROW_OFF_W];
	assign off  = idx[lpbw_pkg::ROW_OFF_W-1:0];
	assign mask = {{(lpbw_pkg::ROW_BITS-1){1'b0}}, 1'b1} << off;

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_q] <= '0;
		end else if (cmd.set) begin
			mem[row] <= rd_q | mask;
		end
		if (cmd.rd) begin
			rd_q <= mem[row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
			member_q   <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_q <= clr_q + RW'(1);
				if (clr_q == RW'(ROWS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (cmd.start) begin
				member_q <= cmd.check;
			end else if (cmd.test) begin
				member_q <= member_q & rd_q[off];
			end
		end
	end

	assign clr_busy = clr_busy_q;
	assign member   = member_q;

endmodule

// File: sv/lpbw_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpbw_dp
// Statistics datapath: saturating login count, bit-serial mean divider,
// Welford product and saturating spread sum, filter index generation and
// the result register.
// ----------------------------------------------------------------------------
module lpbw_dp #(
	parameter int FILTER_BITS = lpbw_pkg::FILTER_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lpbw_pkg::dp_cmd_t                    cmd,
	input  logic [lpbw_pkg::HOUR_W-1:0]          login_hour,
	input  logic [lpbw_pkg::HASH_W-1:0]          device_key,
	input  logic [lpbw_pkg::HASH_W-1:0]          location_key,
	input  logic [lpbw_pkg::HASH_W-1:0]          query_hash,
	input  logic                                 member,
	output logic [$clog2(FILTER_BITS)-1:0]       idx,
	output logic                                 is_member,
	output logic [lpbw_pkg::CNT_W-1:0]           logins_seen,
	output logic [lpbw_pkg::MEAN_W-1:0]          hour_mean,
	output logic [lpbw_pkg::SPREAD_W-1:0]        hour_spread_sum
);

	localparam int IW = $clog2(FILTER_BITS);
	localparam int MW = lpbw_pkg::MEAN_W;
	localparam int DW = lpbw_pkg::DIFF_W;
	localparam int PW = lpbw_pkg::PROD_W;
	localparam int CW = lpbw_pkg::CNT_W;
	localparam int SW = lpbw_pkg::SPREAD_W;
	localparam int FB = lpbw_pkg::FRAC_BITS;
	localparam logic [63:0] MULT = lpbw_pkg::THIRD_MULT;

	logic [lpbw_pkg::HOUR_W-1:0] hour_q;
	logic [lpbw_pkg::HASH_W-1:0] dev_q, geo_q, qry_q;
	logic [CW-1:0]               cnt_q;
	logic [MW-1:0]               mean_q;
	logic [SW-1:0]               spr_q;
	logic signed [DW-1:0]        d_q;
	logic [MW-1:0]               quo_q;
	logic [CW-1:0]               rem_q;
	logic signed [PW-1:0]        prod_q;
	logic [IW-1:0]               idx_q;

	logic                        is_member_q;
	logic [CW-1:0]               logins_q;
	logic [MW-1:0]               mean_out_q;
	logic [SW-1:0]               spr_out_q;

	logic [MW-1:0]               x;
	logic signed [DW-1:0]        dx;
	logic [DW-1:0]               dx_neg;
	logic [MW-1:0]               dx_mag;
	logic [CW:0]                 rem_sh;
	logic [CW:0]                 rem_sub;
	logic                        ge;
	logic signed [PW-1:0]        prod;
	logic [PW-FB-2:0]            prod_sh;
	logic [SW:0]                 sum;
	logic [lpbw_pkg::HASH_W-1:0] h;
	logic [2*IW-1:0]             hmul;
	logic [IW-1:0]               idx_sel;

	assign x      = {hour_q, {FB{1'b0}}};
	assign dx     = $signed({1'b0, x}) - $signed({1'b0, mean_q});
	assign dx_neg = -dx;
	assign dx_mag = dx[DW-1] ? dx_neg[MW-1:0] : dx[MW-1:0];

	// restoring divide, one quotient bit per step
	assign rem_sh  = {rem_q, quo_q[MW-1]};
	assign ge      = rem_sh >= {1'b0, cnt_q};
	assign rem_sub = rem_sh - {1'b0, cnt_q};

	assign prod    = d_q * dx;
	assign prod_sh = prod_q[PW-1] ? '0 : prod_q[PW-2:FB];
	assign sum     = {1'b0, spr_q} + (SW + 1)'(prod_sh);

	always_comb begin
		case (cmd.hsel)
			lpbw_pkg::HSEL_DEV: h = dev_q;
			lpbw_pkg::HSEL_GEO: h = geo_q;
			default:            h = qry_q;
		endcase
	end

	assign hmul = h[IW-1:0] * MULT[IW-1:0];

	always_comb begin
		case (cmd.k)
			2'd0:    idx_sel = h[IW-1:0];
			2'd1:    idx_sel = h[lpbw_pkg::SECOND_SHIFT +: IW];
			2'd2:    idx_sel = hmul[IW-1:0];
			default: idx_sel = h[IW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			hour_q <= login_hour;
			dev_q  <= device_key;
			geo_q  <= location_key;
			qry_q  <= query_hash;
		end
		if (cmd.count) begin
			d_q   <= dx;
			quo_q <= dx_mag;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
			quo_q <= {quo_q[MW-2:0], ge};
		end
		if (cmd.mult) begin
			prod_q <= prod;
		end
		if (cmd.idx_load) begin
			idx_q <= idx_sel;
		end
		if (cmd.load_out) begin
			is_member_q <= member;
			logins_q    <= cnt_q;
			mean_out_q  <= mean_q;
			spr_out_q   <= spr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			mean_q <= '0;
			spr_q  <= '0;
		end else begin
			if (cmd.count && cnt_q != '1) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.mean) begin
				mean_q <= d_q[DW-1] ? mean_q - quo_q : mean_q + quo_q;
			end
			if (cmd.accum) begin
				spr_q <= sum[SW] ? '1 : sum[SW-1:0];
			end
		end
	end

	assign idx             = idx_q;
	assign is_member       = is_member_q;
	assign logins_seen     = logins_q;
	assign hour_mean       = mean_out_q;
	assign hour_spread_sum = spr_out_q;

endmodule

// File: sv/lpbw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpbw_ctrl
// Controller: request handshake, login statistics sequence, filter index
// walk over the three cells of each hash, and the result handshake.
// ----------------------------------------------------------------------------
module lpbw_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic [1:0]            action,
	output logic                  res_valid,
	input  logic                  res_stall,
	input  logic                  clr_busy,
	output lpbw_pkg::dp_cmd_t     dp_cmd,
	output lpbw_pkg::filt_cmd_t   filt_cmd
);

	localparam int STEP_W = $clog2(lpbw_pkg::DIV_STEPS);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COUNT,
		ST_DIV,
		ST_MEAN,
		ST_MULT,
		ST_ACCUM,
		ST_INDEX,
		ST_READ,
		ST_APPLY,
		ST_FINISH
	} state_t;

	state_t               state_q;
	logic [1:0]           action_q;
	lpbw_pkg::hsel_t      hsel_q;
	logic [1:0]           k_q;
	logic [STEP_W-1:0]    step_q;
	logic                 res_valid_q;
	logic                 take;
	logic                 load;
	logic                 is_check;

	assign take     = (state_q == ST_IDLE) && req_valid;
	assign load     = (state_q == ST_FINISH) && (!res_valid_q || !res_stall);
	assign is_check = action_q == lpbw_pkg::ACT_CHECK;

	always_comb begin
		dp_cmd          = '0;
		dp_cmd.capture  = take;
		dp_cmd.count    = state_q == ST_COUNT;
		dp_cmd.div_step = state_q == ST_DIV;
		dp_cmd.mean     = state_q == ST_MEAN;
		dp_cmd.mult     = state_q == ST_MULT;
		dp_cmd.accum    = state_q == ST_ACCUM;
		dp_cmd.idx_load = state_q == ST_INDEX;
		dp_cmd.load_out = load;
		dp_cmd.hsel     = hsel_q;
		dp_cmd.k        = k_q;

		filt_cmd       = '0;
		filt_cmd.start = take;
		filt_cmd.check = action == lpbw_pkg::ACT_CHECK;
		filt_cmd.rd    = state_q == ST_READ;
		filt_cmd.set   = (state_q == ST_APPLY) && !is_check;
		filt_cmd.test  = (state_q == ST_APPLY) && is_check;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			action_q    <= lpbw_pkg::ACT_LOGIN;
			hsel_q      <= lpbw_pkg::HSEL_QRY;
			k_q         <= '0;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					if (!clr_busy) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						action_q <= action;
						hsel_q   <= lpbw_pkg::HSEL_QRY;
						k_q      <= '0;
						case (action)
							lpbw_pkg::ACT_LOGIN: state_q <= ST_COUNT;
							lpbw_pkg::ACT_ADD:   state_q <= ST_INDEX;
							lpbw_pkg::ACT_CHECK: state_q <= ST_INDEX;
							default:             state_q <= ST_FINISH;
						endcase
					end
				end
				ST_COUNT: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(lpbw_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_MEAN;
					end
				end
				ST_MEAN: begin
					state_q <= ST_MULT;
				end
				ST_MULT: begin
					state_q <= ST_ACCUM;
				end
				ST_ACCUM: begin
					hsel_q  <= lpbw_pkg::HSEL_DEV;
					k_q     <= '0;
					state_q <= ST_INDEX;
				end
				ST_INDEX: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (k_q == lpbw_pkg::K_LAST) begin
						k_q <= '0;
						if (hsel_q == lpbw_pkg::HSEL_DEV) begin
							hsel_q  <= lpbw_pkg::HSEL_GEO;
							state_q <= ST_INDEX;
						end else begin
							state_q <= ST_FINISH;
						end
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= ST_INDEX;
					end
				end
				ST_FINISH: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall = state_q != ST_IDLE;
	assign res_valid = res_valid_q;

	// no request taken until the clearing sweep is over
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> (state_q == ST_CLEAR || state_q == ST_IDLE) ? req_stall || state_q == ST_IDLE
		&& $past(state_q) != ST_CLEAR : 1'b1)
		else $error("request window open during clearing sweep");

	a_no_rd_and_wr: assert property (@(posedge clk) disable iff (!arst_n)
		!(filt_cmd.rd && (filt_cmd.set || filt_cmd.test)))
		else $error("filter read and update in the same cycle");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q == STEP_W'(lpbw_pkg::DIV_STEPS - 1)) |=>
		state_q == ST_MEAN)
		else $error("divider did not finish after its step count");

	a_res_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish");

	a_apply_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY) |-> $past(state_q == ST_READ))
		else $error("filter update without a preceding row read");

endmodule

// File: sv/login_profile_bloom_welford.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// login_profile_bloom_welford
// Per-user login profile: Bloom filter of device and location hashes plus
// running mean and Welford spread of the login hour.
// ----------------------------------------------------------------------------
// Request channel: req_valid / req_stall, fields action, login_hour and the
// three hashes. Result channel: res_valid / res_stall, one result per request.
// A request is taken only while the controller is idle; the result sits in an
// output register, so the next request may be taken while it waits.
// Steps per request, from the accepting edge to result valid:
//   login : 1 count, 21 divider steps, mean, product, sum, then index,
//           row read and row write for each of the 6 filter cells, then
//           the result load
//   add, check : index, row read, row write (add) or bit test (check) for each of 3 cells, then the load
//   other action code : the result load only
// A new request is taken only after the result of the last one is loaded.
// The bit-serial mean divider and the single filter memory port set the
// length of each sequence. After reset a clearing sweep zeroes the filter's
// FILTER_BITS/32 rows (64 at 2048 bits), one 32-bit row per cycle,
// with req_stall high. Statistics reset to zero at once. If res_stall holds a
// result, a finished next request waits in its last state until the output
// register frees. FILTER_BITS must be a power of two.
// ----------------------------------------------------------------------------
module login_profile_bloom_welford #(
	parameter int FILTER_BITS = lpbw_pkg::FILTER_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic [1:0]                      action,
	input  logic [lpbw_pkg::HOUR_W-1:0]     login_hour,
	input  logic [lpbw_pkg::HASH_W-1:0]     device_key,
	input  logic [lpbw_pkg::HASH_W-1:0]     location_key,
	input  logic [lpbw_pkg::HASH_W-1:0]     query_hash,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic                            is_member,
	output logic [lpbw_pkg::CNT_W-1:0]      logins_seen,
	output logic [lpbw_pkg::MEAN_W-1:0]     hour_mean,
	output logic [lpbw_pkg::SPREAD_W-1:0]   hour_spread_sum
);

	lpbw_pkg::dp_cmd_t              dp_cmd;
	lpbw_pkg::filt_cmd_t            filt_cmd;
	logic                           clr_busy;
	logic                           member;
	logic [$clog2(FILTER_BITS)-1:0] idx;

	lpbw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.action    (action),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.clr_busy  (clr_busy),
		.dp_cmd    (dp_cmd),
		.filt_cmd  (filt_cmd)
	);

	lpbw_dp #(
		.FILTER_BITS (FILTER_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (dp_cmd),
		.login_hour      (login_hour),
		.device_key      (device_key),
		.location_key    (location_key),
		.query_hash      (query_hash),
		.member          (member),
		.idx             (idx),
		.is_member       (is_member),
		.logins_seen     (logins_seen),
		.hour_mean       (hour_mean),
		.hour_spread_sum (hour_spread_sum)
	);

	lpbw_filter #(
		.FILTER_BITS (FILTER_BITS)
	) u_filter (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (filt_cmd),
		.idx      (idx),
		.clr_busy (clr_busy),
		.member   (member)
	);

endmodule

// File: tb/sv/login_profile_bloom_welford_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// login_profile_bloom_welford_tb
// Self-checking bench for the login profile block. A directed table covers
// the empty-filter and reset values, hashes at their extremes, hours past 23
// and the unused action code. Random requests follow: logins, adds and
// checks, with checks often reusing stored hashes or near misses. A local
// shadow of the Bloom filter and of the running hour mean and spread predicts
// every result the table does not fix. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module login_profile_bloom_welford_tb;

	localparam logic [1:0]  ACT_LOGIN    = lpbw_pkg::ACT_LOGIN;
	localparam logic [1:0]  ACT_ADD      = lpbw_pkg::ACT_ADD;
	localparam logic [1:0]  ACT_CHECK    = lpbw_pkg::ACT_CHECK;
	localparam logic [1:0]  ACT_NONE     = 2'd3;
	localparam int          HOUR_W       = lpbw_pkg::HOUR_W;
	localparam int          IDX_W        = $clog2(lpbw_pkg::FILTER_BITS_DEF);
	localparam logic [63:0] ONES         = '1;
	localparam logic [63:0] SPREAD_MAX   = {1'b0, {63{1'b1}}};
	localparam logic [31:0] COUNT_MAX    = '1;
	localparam int          RANDOM_ITEMS = 1828;
	localparam int          DRAIN_CYCLES = 64;
	localparam int          CYCLE_LIMIT  = 1000000;

	typedef logic [lpbw_pkg::HASH_W-1:0]   hash_t;
	typedef logic [lpbw_pkg::CNT_W-1:0]    count_t;
	typedef logic [lpbw_pkg::MEAN_W-1:0]   mean_t;
	typedef logic [lpbw_pkg::SPREAD_W-1:0] spread_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [HOUR_W-1:0] hour;
		hash_t             dev;
		hash_t             geo;
		hash_t             qry;
	} request_t;

	typedef struct packed {
		logic    member;
		count_t  logins;
		mean_t   mean;
		spread_t spread;
	} result_t;

	typedef struct packed {
		request_t req;
		logic     typed;
		result_t  want;
	} vector_t;

	localparam result_t NO_RES = '0;

	localparam vector_t DIRECTED [22] = '{
		'{'{ACT_CHECK, 5'd0,  64'd0, 64'd0, 64'd0}, 1'b1, '{1'b0, 32'd0, 21'd0, 63'd0}},
		'{'{ACT_NONE,  5'd31, ONES,  ONES,  ONES},  1'b1, '{1'b0, 32'd0, 21'd0, 63'd0}},
		'{'{ACT_LOGIN, 5'd0,  64'd0, ONES,  ONES},  1'b1, '{1'b0, 32'd1, 21'd0, 63'd0}},
		'{'{ACT_CHECK, 5'd0,  ONES,  ONES,  64'd0}, 1'b1, '{1'b1, 32'd1, 21'd0, 63'd0}},
		'{'{ACT_CHECK, 5'd0,  64'd0, 64'd0, ONES},  1'b1, '{1'b1, 32'd1, 21'd0, 63'd0}},
		'{'{ACT_ADD,   5'd31, ONES,  ONES,  64'h8000_0000_0000_0000}, 1'b0, NO_RES},
		'{'{ACT_CHECK, 5'd0,  ONES,  64'd0, 64'h8000_0000_0000_0000}, 1'b0, NO_RES},
		'{'{ACT_CHECK, 5'd0,  64'd0, 64'd0, 64'h0000_0000_0000_0001}, 1'b0, NO_RES},
		'{'{ACT_LOGIN, 5'd23, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, ONES},
			1'b0, NO_RES},
		'{'{ACT_LOGIN, 5'd31, 64'h0000_0000_0000_07FF, 64'h0000_0000_003F_F800, 64'd0},
			1'b0, NO_RES},
		'{'{ACT_LOGIN, 5'd24, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001, ONES},
			1'b0, NO_RES},
		'{'{ACT_LOGIN, 5'd0,  64'h1111_2222_3333_4444, 64'h9999_AAAA_BBBB_CCCC, 64'd0},
			1'b0, NO_RES},
		'{'{ACT_LOGIN, 5'd12, 64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0, ONES},
			1'b0, NO_RES},
		'{'{ACT_NONE,  5'd17, 64'h5555_5555_5555_5555, ONES, 64'hAAAA_AAAA_AAAA_AAAA},
			1'b0, NO_RES},
		'{'{ACT_ADD,   5'd0,  ONES,  ONES,  64'h5555_5555_5555_5555}, 1'b0, NO_RES},
		'{'{ACT_CHECK, 5'd31, ONES,  ONES,  64'h5555_5555_5555_5555}, 1'b0, NO_RES},
		'{'{ACT_CHECK, 5'd0,  64'd0, 64'd0, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, NO_RES},
		'{'{ACT_LOGIN, 5'd23, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'd0},
			1'b0, NO_RES},
		'{'{ACT_CHECK, 5'd0,  64'd0, 64'd0, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, NO_RES},
		'{'{ACT_LOGIN, 5'd31, ONES,  64'd0, 64'd0}, 1'b0, NO_RES},
		'{'{ACT_CHECK, 5'd0,  64'd0, 64'd0, 64'h0123_4567_89AB_CDEF}, 1'b0, NO_RES},
		'{'{ACT_CHECK, 5'd0,  64'd0, 64'd0, 64'hFEDC_BA98_7654_3210}, 1'b0, NO_RES}
	};

	logic                clk             = 1'b0;
	logic                arst_n          = 1'b0;
	logic                req_valid       = 1'b0;
	logic                req_stall;
	logic [1:0]          action          = '0;
	logic [HOUR_W-1:0]   login_hour      = '0;
	hash_t               device_key      = '0;
	hash_t               location_key    = '0;
	hash_t               query_hash      = '0;
	logic                res_valid;
	logic                res_stall       = 1'b0;
	logic                is_member;
	count_t              logins_seen;
	mean_t               hour_mean;
	spread_t             hour_spread_sum;

	bit                  shadow_filter [lpbw_pkg::FILTER_BITS_DEF];
	count_t              shadow_logins   = '0;
	mean_t               shadow_mean     = '0;
	spread_t             shadow_spread   = '0;
	result_t             pending_results [$];
	hash_t               stored_hashes [$];
	logic                idling_on       = 1'b0;
	int                  stall_left      = 0;
	int                  fail_count      = 0;
	int                  cycle_count     = 0;

	login_profile_bloom_welford dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.action          (action),
		.login_hour      (login_hour),
		.device_key      (device_key),
		.location_key    (location_key),
		.query_hash      (query_hash),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.is_member       (is_member),
		.logins_seen     (logins_seen),
		.hour_mean       (hour_mean),
		.hour_spread_sum (hour_spread_sum)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [IDX_W-1:0] cell_of(input hash_t h, input int k);
		hash_t mixed;
		case (k)
			0: mixed = h;
			1: mixed = h >> lpbw_pkg::SECOND_SHIFT;
			default: mixed = h * lpbw_pkg::THIRD_MULT;
		endcase
		return mixed[IDX_W-1:0];
	endfunction

	function automatic void filter_set(input hash_t h);
		for (int k = 0; k < 3; k++)
			shadow_filter[cell_of(h, k)] = 1'b1;
	endfunction

	function automatic logic filter_hit(input hash_t h);
		logic hit;
		hit = 1'b1;
		for (int k = 0; k < 3; k++)
			if (!shadow_filter[cell_of(h, k)])
				hit = 1'b0;
		return hit;
	endfunction

	// running mean and welford spread, signed 64-bit intermediates
	function automatic void hour_update(input logic [HOUR_W-1:0] hour);
		longint      x, m, d, d2, nm, p;
		logic [63:0] sum;
		if (shadow_logins != COUNT_MAX)
			shadow_logins = shadow_logins + 1'b1;
		x = longint'({hour, {lpbw_pkg::FRAC_BITS{1'b0}}});
		m = longint'(shadow_mean);
		d = x - m;
		nm = m + d / longint'(shadow_logins);
		d2 = x - nm;
		p = d * d2;
		shadow_mean = nm[lpbw_pkg::MEAN_W-1:0];
		sum = {1'b0, shadow_spread} +
			((p >= 0) ? 64'(p >> lpbw_pkg::FRAC_BITS) : 64'd0);
		if (sum > SPREAD_MAX)
			sum = SPREAD_MAX;
		shadow_spread = sum[lpbw_pkg::SPREAD_W-1:0];
	endfunction

	function automatic result_t profile_predict(input request_t r);
		result_t res;
		res.member = 1'b0;
		case (r.action)
			ACT_LOGIN: begin
				hour_update(r.hour);
				filter_set(r.dev);
				filter_set(r.geo);
			end
			ACT_ADD: filter_set(r.qry);
			ACT_CHECK: res.member = filter_hit(r.qry);
			default: ;
		endcase
		res.logins = shadow_logins;
		res.mean = shadow_mean;
		res.spread = shadow_spread;
		return res;
	endfunction

	function automatic request_t random_request();
		request_t r;
		int       pick;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			r.action = ACT_LOGIN;
		else if (pick < 30)
			r.action = ACT_ADD;
		else if (pick < 90)
			r.action = ACT_CHECK;
		else
			r.action = ACT_NONE;
		if ($urandom_range(0, 9) == 0)
			r.hour = HOUR_W'($urandom_range(24, 31));
		else
			r.hour = HOUR_W'($urandom_range(0, 23));
		r.dev = {$urandom, $urandom};
		r.geo = {$urandom, $urandom};
		r.qry = {$urandom, $urandom};
		if (r.action == ACT_CHECK && stored_hashes.size() != 0 && $urandom_range(0, 1)) begin
			r.qry = stored_hashes[$urandom_range(0, stored_hashes.size() - 1)];
			// near miss
			if ($urandom_range(0, 3) == 0)
				r.qry = r.qry ^ (64'd1 << $urandom_range(0, 63));
		end
		return r;
	endfunction

	task automatic send_request(input request_t r, input logic gaps);
		int gap;
		if (gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action <= r.action;
		login_hour <= r.hour;
		device_key <= r.dev;
		location_key <= r.geo;
		query_hash <= r.qry;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (idling_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 15);
		res_stall <= (stall_left > 0);
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: no request pending");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (is_member !== want.member) begin
					$error("is_member: expected %0d, got %0d", want.member, is_member);
					fail_count++;
				end
				if (logins_seen !== want.logins) begin
					$error("logins_seen: expected %0d, got %0d", want.logins, logins_seen);
					fail_count++;
				end
				if (hour_mean !== want.mean) begin
					$error("hour_mean: expected %0d, got %0d", want.mean, hour_mean);
					fail_count++;
				end
				if (hour_spread_sum !== want.spread) begin
					$error("hour_spread_sum: expected %0d, got %0d", want.spread,
						hour_spread_sum);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : stimulus
		request_t r;
		result_t  got;
		logic     quiet;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		idling_on <= 1'b1;

		foreach (DIRECTED[i]) begin
			send_request(DIRECTED[i].req, 1'b1);
			got = profile_predict(DIRECTED[i].req);
			pending_results.push_back(DIRECTED[i].typed ? DIRECTED[i].want : got);
		end

		drain_results();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i >= 400 && i < 550) || (i >= RANDOM_ITEMS - 250);
			idling_on <= !quiet;
			if (i == RANDOM_ITEMS / 2)
				drain_results();
			r = random_request();
			send_request(r, !quiet);
			pending_results.push_back(profile_predict(r));
			if (r.action == ACT_LOGIN) begin
				stored_hashes.push_back(r.dev);
				stored_hashes.push_back(r.geo);
			end else if (r.action == ACT_ADD) begin
				stored_hashes.push_back(r.qry);
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
